/* hw/rtl/mlr_pkg.sv */
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types and codes for the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

    // request codes on req_type
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // command control that travels with each queued word
    typedef struct packed {
        logic is_start;
        logic vertical;
    } t_cmd_ctl;

endpackage

/* hw/rtl/mlr_front.sv */
// ----------------------------------------------------------------------------
// mlr_front
// Accepts requests, classifies them and works out the line setup for starts:
// major axis, scan order, start point, end of scan and the two spans.
// ----------------------------------------------------------------------------
module mlr_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_push,
    output logic                  o_full,
    input  logic                  i_req_type,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic [7:0]            i_line_color,
    input  logic                  i_q_full,
    output logic                  o_q_wr,
    output mlr_pkg::t_cmd_ctl     o_ctl,
    output logic [7:0]            o_color,
    output logic [COORD_BITS-1:0] o_ax,
    output logic [COORD_BITS-1:0] o_ay,
    output logic [COORD_BITS-1:0] o_major_end,
    output logic [COORD_BITS-1:0] o_dmaj,
    output logic [COORD_BITS:0]   o_dmin
);
    import mlr_pkg::*;

    logic [COORD_BITS:0] dx, dy, adx, ady;
    logic                vertical;
    logic                swap;

    always_comb begin
        dx  = {1'b0, i_end_x} - {1'b0, i_start_x};
        dy  = {1'b0, i_end_y} - {1'b0, i_start_y};
        adx = dx[COORD_BITS] ? -dx : dx;
        ady = dy[COORD_BITS] ? -dy : dy;
        // equal spans scan vertically
        vertical = !(adx > ady);
        swap     = vertical ? dy[COORD_BITS] : dx[COORD_BITS];

        o_ctl.is_start = (i_req_type == REQ_START);
        o_ctl.vertical = vertical;
        o_color        = i_line_color;
        o_ax           = swap ? i_end_x : i_start_x;
        o_ay           = swap ? i_end_y : i_start_y;
        if (vertical) begin
            o_major_end = swap ? i_start_y : i_end_y;
            o_dmaj      = ady[COORD_BITS-1:0];
            o_dmin      = swap ? -dx : dx;
        end else begin
            o_major_end = swap ? i_start_x : i_end_x;
            o_dmaj      = adx[COORD_BITS-1:0];
            o_dmin      = swap ? -dy : dy;
        end
    end

    assign o_full = i_q_full;
    assign o_q_wr = i_push && !i_q_full;

endmodule

/* hw/rtl/mlr_fifo.sv */
// ----------------------------------------------------------------------------
// mlr_fifo
// Short command queue between the setup front and the scan back.
// ----------------------------------------------------------------------------
module mlr_fifo #(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [DATA_BITS-1:0] i_data,
    output logic                 o_full,
    input  logic                 i_rd,
    output logic                 o_valid,
    output logic [DATA_BITS-1:0] o_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [AW-1:0]        r_wptr, r_rptr, n_wptr, n_rptr;
    logic [CW-1:0]        r_count, n_count;
    logic                 do_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_rd   = i_rd && o_valid;

    // pointers wrap at the last entry so any depth works
    always_comb begin
        n_wptr  = !i_wr  ? r_wptr : ((r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1);
        n_rptr  = !do_rd ? r_rptr : ((r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1);
        n_count = r_count + CW'(i_wr) - CW'(do_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

/* hw/rtl/mlr_back.sv */
// ----------------------------------------------------------------------------
// mlr_back
// Scan engine: loads the decision terms on a start, walks one pixel per step
// and holds each pixel in an output register until it is taken.
// ----------------------------------------------------------------------------
module mlr_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_q_rd,
    input  mlr_pkg::t_cmd_ctl     i_ctl,
    input  logic [7:0]            i_color,
    input  logic [COORD_BITS-1:0] i_ax,
    input  logic [COORD_BITS-1:0] i_ay,
    input  logic [COORD_BITS-1:0] i_major_end,
    input  logic [COORD_BITS-1:0] i_dmaj,
    input  logic [COORD_BITS:0]   i_dmin,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [7:0]            o_pixel_color,
    output logic                  o_last_pixel
);
    import mlr_pkg::*;

    localparam int DW = COORD_BITS + 3;

    logic                  r_active, n_active;
    logic                  r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0] r_cx, n_cx, r_cy, n_cy, r_mend, n_mend;
    logic [DW-1:0]         r_dec, n_dec, r_sstr, n_sstr, r_sdiag, n_sdiag;
    logic                  r_vert, n_vert, r_fall, n_fall;
    logic [7:0]            r_color, n_color;
    logic [COORD_BITS-1:0] r_px, n_px, r_py, n_py;
    logic [7:0]            r_pc, n_pc;
    logic                  r_pl, n_pl;

    logic                  out_ready, take, emit, last, diag;
    logic [COORD_BITS-1:0] major, minor, major_nx, minor_nx;
    logic [DW-1:0]         dmin2, dmaj_e, dmaj2;

    always_comb begin
        out_ready = !r_out_valid || i_pop;
        // starts and idle steps need no output slot
        take      = i_q_valid && (i_ctl.is_start || !r_active || out_ready);
        emit      = take && !i_ctl.is_start && r_active;

        major = r_vert ? r_cy : r_cx;
        minor = r_vert ? r_cx : r_cy;
        last  = !(major < r_mend);
        diag  = r_fall ? (r_dec[DW-1] || (r_dec == '0))
                       : !(r_dec[DW-1] || (r_dec == '0));
        major_nx = major + 1'b1;
        minor_nx = !diag ? minor : (r_fall ? minor - 1'b1 : minor + 1'b1);

        dmin2  = {i_dmin[COORD_BITS], i_dmin, 1'b0};
        dmaj_e = {3'b000, i_dmaj};
        dmaj2  = {2'b00, i_dmaj, 1'b0};

        n_active    = r_active;
        n_out_valid = r_out_valid;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_mend      = r_mend;
        n_dec       = r_dec;
        n_sstr      = r_sstr;
        n_sdiag     = r_sdiag;
        n_vert      = r_vert;
        n_fall      = r_fall;
        n_color     = r_color;
        n_px        = r_px;
        n_py        = r_py;
        n_pc        = r_pc;
        n_pl        = r_pl;

        if (i_pop) begin
            n_out_valid = 1'b0;
        end

        if (take && i_ctl.is_start) begin
            n_active = 1'b1;
            n_cx     = i_ax;
            n_cy     = i_ay;
            n_mend   = i_major_end;
            n_vert   = i_ctl.vertical;
            n_fall   = i_dmin[COORD_BITS];
            n_color  = i_color;
            n_sstr   = dmin2;
            n_dec    = i_dmin[COORD_BITS] ? dmin2 + dmaj_e : dmin2 - dmaj_e;
            n_sdiag  = i_dmin[COORD_BITS] ? dmin2 + dmaj2  : dmin2 - dmaj2;
        end else if (emit) begin
            n_out_valid = 1'b1;
            n_px        = r_cx;
            n_py        = r_cy;
            n_pc        = r_color;
            n_pl        = last;
            if (last) begin
                n_active = 1'b0;
            end else begin
                n_dec = r_dec + (diag ? r_sdiag : r_sstr);
                n_cx  = r_vert ? minor_nx : major_nx;
                n_cy  = r_vert ? major_nx : minor_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_mend  <= n_mend;
        r_dec   <= n_dec;
        r_sstr  <= n_sstr;
        r_sdiag <= n_sdiag;
        r_vert  <= n_vert;
        r_fall  <= n_fall;
        r_color <= n_color;
        r_px    <= n_px;
        r_py    <= n_py;
        r_pc    <= n_pc;
        r_pl    <= n_pl;
    end

    assign o_q_rd        = take;
    assign o_empty       = !r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pc;
    assign o_last_pixel  = r_pl;

endmodule

/* hw/rtl/midpoint_line_rasterizer_top.sv */
// Throughput: one request per cycle while full is low; each step on an active line
// yields one pixel, and a result that is not popped stalls the steps behind it.
// Path: a step's word is written into the command queue, the scan engine adds and
// compares while it waits there, and its pixel then loads into the pixel register.
// full is raised only while the command queue holds QUEUE_DEPTH words.
// Reset (synchronous, active low) empties the queue and output register.
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_top
// Midpoint line generator: setup front, command queue and scan back.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_top #(
    parameter int COORD_BITS  = 12,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_req_type,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic [7:0]            i_line_color,
    output logic                  empty,
    input  logic                  pop,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [7:0]            o_pixel_color,
    output logic                  o_last_pixel
);
    import mlr_pkg::*;

    localparam int QW = $bits(t_cmd_ctl) + 8 + 5 * COORD_BITS + 1;

    logic                  q_wr, q_full, q_valid, q_rd;
    t_cmd_ctl              f_ctl, b_ctl;
    logic [7:0]            f_color, b_color;
    logic [COORD_BITS-1:0] f_ax, f_ay, f_mend, f_dmaj;
    logic [COORD_BITS-1:0] b_ax, b_ay, b_mend, b_dmaj;
    logic [COORD_BITS:0]   f_dmin, b_dmin;
    logic [QW-1:0]         q_wdata, q_rdata;

    mlr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_push       (push),
        .o_full       (full),
        .i_req_type   (i_req_type),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_line_color (i_line_color),
        .i_q_full     (q_full),
        .o_q_wr       (q_wr),
        .o_ctl        (f_ctl),
        .o_color      (f_color),
        .o_ax         (f_ax),
        .o_ay         (f_ay),
        .o_major_end  (f_mend),
        .o_dmaj       (f_dmaj),
        .o_dmin       (f_dmin)
    );

    assign q_wdata = {f_ctl, f_color, f_ax, f_ay, f_mend, f_dmaj, f_dmin};
    assign {b_ctl, b_color, b_ax, b_ay, b_mend, b_dmaj, b_dmin} = q_rdata;

    mlr_fifo #(.DATA_BITS(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    mlr_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_q_rd        (q_rd),
        .i_ctl         (b_ctl),
        .i_color       (b_color),
        .i_ax          (b_ax),
        .i_ay          (b_ay),
        .i_major_end   (b_mend),
        .i_dmaj        (b_dmaj),
        .i_dmin        (b_dmin),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

/* hw/rtl/mlr_checker.sv */
// ----------------------------------------------------------------------------
// mlr_checker
// Port-level checks on the line rasterizer's queues.
// ----------------------------------------------------------------------------
module mlr_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  push,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input logic [COORD_BITS-1:0] o_pixel_x,
    input logic [COORD_BITS-1:0] o_pixel_y,
    input logic [7:0]            o_pixel_color,
    input logic                  o_last_pixel
);

    // reset leaves nothing to read and room to write
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    // full can only rise on a write
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(full) |-> $past(push))
        else $error("full rose without a push");

    // the output register only drains on a pop
    a_empty_needs_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(empty) |-> $past(pop))
        else $error("result vanished without a pop");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_pixel_x) && $stable(o_pixel_y)
            && $stable(o_pixel_color) && $stable(o_last_pixel))
        else $error("waiting word changed");

endmodule

bind midpoint_line_rasterizer_top mlr_checker #(.COORD_BITS(COORD_BITS)) u_mlr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_pixel_x     (o_pixel_x),
    .o_pixel_y     (o_pixel_y),
    .o_pixel_color (o_pixel_color),
    .o_last_pixel  (o_last_pixel)
);
